// File: hdl/pol3_pkg.sv
`timescale 1ns / 1ps
package pol3_pkg;

   localparam int CW  = 32;          // coordinate width
   localparam int FB  = 16;          // fraction bits
   localparam int DW  = CW + 1;      // exact coordinate difference
   localparam int PW  = 2 * DW;      // product, and magnitude of a dot product
   localparam int SW  = PW + 2;      // signed sum of three products
   localparam int MW  = PW + FB;     // scaled dividend
   localparam int QW  = CW + 1;      // quotient bits developed by the divider
   localparam int PRW = DW + CW;     // b * t product
   localparam int VW  = PRW + 1;     // b * t + origin before clamping

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [DW-1:0] diff_type;
   typedef coord_type [2:0] cvec_type;
   typedef diff_type [2:0] dvec_type;

   typedef struct packed {
      coord_type origin_x;
      coord_type origin_y;
      coord_type origin_z;
      coord_type dir_pt_x;
      coord_type dir_pt_y;
      coord_type dir_pt_z;
      coord_type query_x;
      coord_type query_y;
      coord_type query_z;
   } req_type;

   typedef struct packed {
      coord_type proj_x;
      coord_type proj_y;
      coord_type proj_z;
      logic      degenerate;
      logic      overflowed;
   } rsp_type;

   typedef struct packed {
      cvec_type        org;
      dvec_type        bv;
      logic [PW-1:0]   dbb;
      logic [PW-1:0]   mag;
      logic            tneg;
      logic            degen;
   } dot_type;

   typedef struct packed {
      cvec_type        org;
      dvec_type        bv;
      logic [PW-1:0]   dbb;
      logic [PW-1:0]   rem;
      logic [QW-1:0]   low;
      logic [QW-1:0]   quo;
      logic            qovf;
      logic            tneg;
      logic            degen;
   } stg_type;

endpackage

// File: hdl/pol3_dot.sv
`timescale 1ns / 1ps
module pol3_dot (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  pol3_pkg::req_type req_word,
   output logic              out_valid,
   output pol3_pkg::dot_type out_dot
);
   import pol3_pkg::*;

   cvec_type org_v, dir_v, qry_v;

   logic     v1_ff, v2_ff, v3_ff, v4_ff;
   cvec_type org1_ff, org2_ff, org3_ff;
   dvec_type bv1_ff, bv2_ff, bv3_ff;
   dvec_type av1_ff;
   dvec_type bv1_in, av1_in;

   logic signed [PW-1:0] bb2_ff [3];
   logic signed [PW-1:0] ab2_ff [3];
   logic signed [PW-1:0] bb2_in [3];
   logic signed [PW-1:0] ab2_in [3];

   logic signed [SW-1:0] bb3_ff, ab3_ff, bb3_in, ab3_in;
   dot_type              dot4_ff, dot4_in;
   logic [SW-1:0]        ab_abs;

   assign org_v = {req_word.origin_z, req_word.origin_y, req_word.origin_x};
   assign dir_v = {req_word.dir_pt_z, req_word.dir_pt_y, req_word.dir_pt_x};
   assign qry_v = {req_word.query_z, req_word.query_y, req_word.query_x};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         bv1_in[k] = DW'($signed(dir_v[k])) - DW'($signed(org_v[k]));
         av1_in[k] = DW'($signed(qry_v[k])) - DW'($signed(org_v[k]));
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         bb2_in[k] = PW'($signed(bv1_ff[k])) * PW'($signed(bv1_ff[k]));
         ab2_in[k] = PW'($signed(av1_ff[k])) * PW'($signed(bv1_ff[k]));
      end
   end

   assign bb3_in = SW'(bb2_ff[0]) + SW'(bb2_ff[1]) + SW'(bb2_ff[2]);
   assign ab3_in = SW'(ab2_ff[0]) + SW'(ab2_ff[1]) + SW'(ab2_ff[2]);

   assign ab_abs = ab3_ff[SW-1] ? (SW'(0) - ab3_ff) : ab3_ff;

   always_comb begin
      dot4_in.org   = org3_ff;
      dot4_in.bv    = bv3_ff;
      dot4_in.dbb   = bb3_ff[PW-1:0];
      dot4_in.mag   = ab_abs[PW-1:0];
      dot4_in.tneg  = ab3_ff[SW-1];
      dot4_in.degen = (bb3_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (en) begin
         org1_ff <= org_v;
         bv1_ff  <= bv1_in;
         av1_ff  <= av1_in;
         org2_ff <= org1_ff;
         bv2_ff  <= bv1_ff;
         for (int k = 0; k < 3; k++) begin
            bb2_ff[k] <= bb2_in[k];
            ab2_ff[k] <= ab2_in[k];
         end
         org3_ff <= org2_ff;
         bv3_ff  <= bv2_ff;
         bb3_ff  <= bb3_in;
         ab3_ff  <= ab3_in;
         dot4_ff <= dot4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_dot   = dot4_ff;

endmodule

// File: hdl/pol3_div.sv
`timescale 1ns / 1ps
module pol3_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  pol3_pkg::dot_type in_dot,
   output logic              out_valid,
   output pol3_pkg::stg_type out_stg
);
   import pol3_pkg::*;

   logic [QW:0] vld_ff;
   stg_type     st_ff [QW+1];
   stg_type     st_in [QW+1];

   logic [MW-1:0] num;
   logic [PW-1:0] hi_ext;

   // Stage zero: if the upper dividend bits already reach the divisor the
   // quotient cannot fit, otherwise they seed the remainder.
   assign num    = {in_dot.mag, {FB{1'b0}}};
   assign hi_ext = PW'(num[MW-1:QW]);

   always_comb begin
      st_in[0].org   = in_dot.org;
      st_in[0].bv    = in_dot.bv;
      st_in[0].dbb   = in_dot.dbb;
      st_in[0].qovf  = (hi_ext >= in_dot.dbb);
      st_in[0].rem   = st_in[0].qovf ? '0 : hi_ext;
      st_in[0].low   = num[QW-1:0];
      st_in[0].quo   = '0;
      st_in[0].tneg  = in_dot.tneg;
      st_in[0].degen = in_dot.degen;
   end

   // One restoring step per stage, most significant quotient bit first.
   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [PW:0] rs;
      logic [PW:0] df;
      logic        ge;

      assign rs = {st_ff[k-1].rem, st_ff[k-1].low[QW-1]};
      assign df = rs - {1'b0, st_ff[k-1].dbb};
      assign ge = (rs >= {1'b0, st_ff[k-1].dbb});

      always_comb begin
         st_in[k]     = st_ff[k-1];
         st_in[k].rem = ge ? df[PW-1:0] : rs[PW-1:0];
         st_in[k].low = {st_ff[k-1].low[QW-2:0], 1'b0};
         st_in[k].quo = {st_ff[k-1].quo[QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QW-1:0], in_valid};
      end
      if (en) begin
         for (int k = 0; k <= QW; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_stg   = st_ff[QW];

endmodule

// File: hdl/pol3_scale.sv
`timescale 1ns / 1ps
module pol3_scale (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  pol3_pkg::stg_type in_stg,
   output logic              rsp_valid,
   output pol3_pkg::rsp_type rsp_word
);
   import pol3_pkg::*;

   localparam logic signed [VW-1:0] VMAX = {{(VW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [VW-1:0] VMIN = {{(VW-CW+1){1'b1}}, {(CW-1){1'b0}}};
   localparam logic signed [PRW-1:0] RND = {{(PRW-FB){1'b0}}, {FB{1'b1}}};

   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;

   // Parameter t, clamped to the coordinate range.
   logic [QW-1:0] lim, tm, tw;
   logic          sat;
   coord_type     t1_ff;
   logic          tovf1_ff, tovf2_ff, tovf3_ff;
   logic          dg1_ff, dg2_ff, dg3_ff;
   cvec_type      org1_ff, org2_ff, org3_ff;
   dvec_type      bv1_ff;

   logic signed [PRW-1:0] prod2_ff [3];
   logic signed [PRW-1:0] prod2_in [3];
   logic signed [PRW-1:0] shv [3];
   logic signed [VW-1:0]  sum3_ff [3];
   logic signed [VW-1:0]  sum3_in [3];

   coord_type cl [3];
   logic [2:0] clamp;
   rsp_type   rsp_word_ff, rsp_word_in;

   assign lim = {1'b0, in_stg.tneg, {(CW-1){~in_stg.tneg}}};
   assign sat = in_stg.qovf || (in_stg.quo > lim);
   assign tm  = sat ? lim : in_stg.quo;
   assign tw  = in_stg.tneg ? (QW'(0) - tm) : tm;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod2_in[k] = PRW'($signed(bv1_ff[k])) * PRW'(t1_ff);
      end
   end

   // The scaled product is truncated toward zero, hence the bias on
   // negative values before the arithmetic shift.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         shv[k]     = (prod2_ff[k] + (prod2_ff[k][PRW-1] ? RND : PRW'(0))) >>> FB;
         sum3_in[k] = VW'(shv[k]) + VW'($signed(org2_ff[k]));
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         clamp[k] = 1'b1;
         if (sum3_ff[k] > VMAX) begin
            cl[k] = VMAX[CW-1:0];
         end else if (sum3_ff[k] < VMIN) begin
            cl[k] = VMIN[CW-1:0];
         end else begin
            cl[k]    = sum3_ff[k][CW-1:0];
            clamp[k] = 1'b0;
         end
      end
      if (dg3_ff) begin
         rsp_word_in.proj_x     = org3_ff[0];
         rsp_word_in.proj_y     = org3_ff[1];
         rsp_word_in.proj_z     = org3_ff[2];
         rsp_word_in.degenerate = 1'b1;
         rsp_word_in.overflowed = 1'b0;
      end else begin
         rsp_word_in.proj_x     = cl[0];
         rsp_word_in.proj_y     = cl[1];
         rsp_word_in.proj_z     = cl[2];
         rsp_word_in.degenerate = 1'b0;
         rsp_word_in.overflowed = tovf3_ff | (|clamp);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
      if (en) begin
         t1_ff    <= tw[CW-1:0];
         tovf1_ff <= sat;
         dg1_ff   <= in_stg.degen;
         org1_ff  <= in_stg.org;
         bv1_ff   <= in_stg.bv;
         tovf2_ff <= tovf1_ff;
         dg2_ff   <= dg1_ff;
         org2_ff  <= org1_ff;
         tovf3_ff <= tovf2_ff;
         dg3_ff   <= dg2_ff;
         org3_ff  <= org2_ff;
         for (int k = 0; k < 3; k++) begin
            prod2_ff[k] <= prod2_in[k];
            sum3_ff[k]  <= sum3_in[k];
         end
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// File: hdl/point_onto_line_projection_3d.sv
// An accepted request word passes through 4 dot-product stages, 34 divider stages and
// 4 scaling stages before its response word is presented.
// Throughput: one word per cycle unless stalled; one quotient bit per divider step.
// A stalled response holds the whole pipeline, so nothing is lost or repeated.
// Reset is synchronous and active high; it clears all valid bits, data is not reset.
`timescale 1ns / 1ps
module point_onto_line_projection_3d (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pol3_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pol3_pkg::rsp_type rsp_word
);
   import pol3_pkg::*;

   logic    en;
   logic    dot_valid, div_valid;
   dot_type dot_word;
   stg_type div_word;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   pol3_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .req_word  (req_word),
      .out_valid (dot_valid),
      .out_dot   (dot_word)
   );

   pol3_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dot_valid),
      .in_dot    (dot_word),
      .out_valid (div_valid),
      .out_stg   (div_word)
   );

   pol3_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_stg    (div_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

`ifndef ASSERT_OFF
   a_degen_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.degenerate |-> !rsp_word.overflowed)
      else $error("degenerate response flagged as overflowed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(div_valid) && $stable(dot_valid))
      else $error("pipeline moved while the output was stalled");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import pol3_pkg::*;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type want;
   } row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_word;

   rsp_type pending_proj[$];
   int      mismatches = 0;
   bit      no_idle = 1'b0;

   point_onto_line_projection_3d u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

   // Projection of the query point onto the line, saturating as the block does.
   function automatic rsp_type project_point(req_type r);
      logic signed [99:0] o[3], b[3], a[3];
      logic signed [99:0] dbb, dab, t, bt, v;
      logic [99:0] m, q, tm, mb, mt, p, lim;
      logic tneg, ovf, pneg;
      rsp_type res;
      o[0] = r.origin_x;  o[1] = r.origin_y;  o[2] = r.origin_z;
      b[0] = r.dir_pt_x;  b[1] = r.dir_pt_y;  b[2] = r.dir_pt_z;
      a[0] = r.query_x;   a[1] = r.query_y;   a[2] = r.query_z;
      for (int k = 0; k < 3; k++) begin
         b[k] = b[k] - o[k];
         a[k] = a[k] - o[k];
      end
      dbb = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
      if (dbb == 0) begin
         res.proj_x = r.origin_x;
         res.proj_y = r.origin_y;
         res.proj_z = r.origin_z;
         res.degenerate = 1'b1;
         res.overflowed = 1'b0;
         return res;
      end
      dab = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      tneg = dab < 0;
      m = tneg ? -dab : dab;
      m = m << FB;
      q = m / dbb;
      lim = tneg ? 100'd2147483648 : 100'd2147483647;
      ovf = 1'b0;
      tm = q;
      if (q > lim) begin
         tm = lim;
         ovf = 1'b1;
      end
      t = tneg ? -$signed(tm) : $signed(tm);
      mt = tm;
      for (int k = 0; k < 3; k++) begin
         pneg = (b[k] < 0) != (t < 0);
         mb = (b[k] < 0) ? -b[k] : b[k];
         p = (mb * mt) >> FB;
         if (p > (100'd1 << 62)) begin
            v = pneg ? -100'sd2147483648 : 100'sd2147483647;
            ovf = 1'b1;
         end else begin
            bt = pneg ? -$signed(p) : $signed(p);
            v = bt + o[k];
            if (v > 100'sd2147483647) begin
               v = 100'sd2147483647;
               ovf = 1'b1;
            end else if (v < -100'sd2147483648) begin
               v = -100'sd2147483648;
               ovf = 1'b1;
            end
         end
         case (k)
            0: res.proj_x = v[CW-1:0];
            1: res.proj_y = v[CW-1:0];
            default: res.proj_z = v[CW-1:0];
         endcase
      end
      res.degenerate = 1'b0;
      res.overflowed = ovf;
      return res;
   endfunction

   function automatic req_type make_req(coord_type ox, oy, oz, px, py, pz, qx, qy, qz);
      req_type r;
      r = '{ox, oy, oz, px, py, pz, qx, qy, qz};
      return r;
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
         2: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
         default: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                             : 32'h8000_0000 + $urandom_range(3);
      endcase
   endfunction

   // Mostly well-formed triples; some have the query on or near the line itself.
   function automatic req_type rand_req();
      req_type r;
      coord_type o[3], d[3];
      int s;
      for (int k = 0; k < 3; k++) o[k] = rand_coord();
      r = make_req(o[0], o[1], o[2], rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord());
      case ($urandom_range(7))
         0: begin
            r.dir_pt_x = r.origin_x;
            r.dir_pt_y = r.origin_y;
            r.dir_pt_z = r.origin_z;
         end
         1, 2: begin
            for (int k = 0; k < 3; k++)
               d[k] = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            s = $signed($urandom_range(0, 16)) - 8;
            r.dir_pt_x = o[0] + d[0];
            r.dir_pt_y = o[1] + d[1];
            r.dir_pt_z = o[2] + d[2];
            r.query_x = o[0] + s * d[0] + $signed($urandom_range(0, 64)) - 32;
            r.query_y = o[1] + s * d[1];
            r.query_z = o[2] + s * d[2];
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send(req_type w);
      int gap;
      gap = no_idle ? 0 : $urandom_range(3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_proj.push_back(project_point(w));
      @(negedge clock);
   endtask

   // Response side: a random stall before each word.
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(3);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_proj.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected response word %h", rsp_word);
         end else begin
            if (rsp_word !== pending_proj[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %h %h %h deg %b ovf %b, got %h %h %h deg %b ovf %b",
                           pending_proj[0].proj_x, pending_proj[0].proj_y,
                           pending_proj[0].proj_z, pending_proj[0].degenerate,
                           pending_proj[0].overflowed, rsp_word.proj_x, rsp_word.proj_y,
                           rsp_word.proj_z, rsp_word.degenerate, rsp_word.overflowed);
            end
            void'(pending_proj.pop_front());
         end
      end
   end

   initial begin
      row_type rows[$];
      row_type rw;
      coord_type mx, mn, one;
      mx = 32'h7fff_ffff;
      mn = 32'h8000_0000;
      one = 32'h0001_0000;

      // Zero direction, with the origin at zero or at extreme values, gives back the origin.
      rw.typed = 1'b1;
      rw.word = '0;
      rw.want = '{32'h0, 32'h0, 32'h0, 1'b1, 1'b0};
      rows.push_back(rw);
      rw.word = make_req(mx, mn, mx, mx, mn, mx, mn, mx, mn);
      rw.want = '{mx, mn, mx, 1'b1, 1'b0};
      rows.push_back(rw);
      rw.word = make_req(mn, mx, 5, mn, mx, 5, 0, 0, 0);
      rw.want = '{mn, mx, 32'sd5, 1'b1, 1'b0};
      rows.push_back(rw);
      // Unit direction along x or z: the projection keeps the query's coordinate on that axis.
      rw.word = make_req(0, 0, 0, one, 0, 0, 2 * one, 5 * one, -7 * one);
      rw.want = '{2 * one, 32'h0, 32'h0, 1'b0, 1'b0};
      rows.push_back(rw);
      rw.word = make_req(0, 0, 0, 0, 0, one, 0, 3, -3 * one);
      rw.want = '{32'h0, 32'h0, -3 * one, 1'b0, 1'b0};
      rows.push_back(rw);
      rw.typed = 1'b0;
      // Tiny direction with a far query saturates t, both signs.
      rows.push_back('{make_req(0, 0, 0, 1, 0, 0, mx, 0, 0), 1'b0, '0});
      rows.push_back('{make_req(0, 0, 0, 1, 0, 0, mn, 0, 0), 1'b0, '0});
      rows.push_back('{make_req(0, 0, 0, 0, -1, 0, 0, mx, 0), 1'b0, '0});
      // Full-span differences in every axis.
      rows.push_back('{make_req(mn, mn, mn, mx, mx, mx, mx, mx, mx), 1'b0, '0});
      rows.push_back('{make_req(mx, mx, mx, mn, mn, mn, mn, mx, mn), 1'b0, '0});
      rows.push_back('{make_req(mn, mx, mn, mx, mn, mx, 0, 0, 0), 1'b0, '0});
      rows.push_back('{make_req(mx, 0, mn, mx - 1, 1, mn + 1, mn, mx, mx), 1'b0, '0});
      // Results that land exactly on the coordinate limits after adding the origin, and negative t.
      rows.push_back('{make_req(mx - one, 0, 0, mx, 0, 0, mx, 0, 0), 1'b0, '0});
      rows.push_back('{make_req(0, 0, 0, one, one, one, -4 * one, -one, 3), 1'b0, '0});
      rows.push_back('{make_req(mn + one, 0, 0, mn + 2 * one, 0, 0, mn, 0, 0), 1'b0, '0});
      rows.push_back('{make_req(-1, -1, -1, 1, 1, 1, -1, -1, -1), 1'b0, '0});
      rows.push_back('{make_req(3, 4, 5, 3, 4, 6, 7, 8, 9), 1'b0, '0});

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         send(rows[i].word);
         if (rows[i].typed && pending_proj[$] !== rows[i].want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Table row %0d: expected %h, predicted %h", i, rows[i].want,
                        pending_proj[$]);
         end
      end

      for (int n = 0; n < 1850; n++) begin
         if (n % 400 == 200) no_idle = 1'b1;
         if (n % 400 == 300) no_idle = 1'b0;
         if (n == 900) begin
            // Let the pipeline drain completely before carrying on.
            req_valid <= 1'b0;
            while (pending_proj.size() != 0) @(negedge clock);
         end
         send(rand_req());
      end
      req_valid <= 1'b0;

      while (pending_proj.size() != 0) @(negedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0 && pending_proj.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
